>>> design/tduart_pkg.sv
// ----------------------------------------------------------------------------
// tduart_pkg
// Shared types and constants for the tick driven 8n1 uart.
// ----------------------------------------------------------------------------
package tduart_pkg;

  // default transmit buffer depth
  localparam int unsigned TxDepthDef = 16;

  // item opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_PUSH  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  // field widths
  localparam int unsigned OpW     = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned InDataW = 16;
  localparam int unsigned OutDataW = 16;

  // decoded command for one accepted transaction
  typedef struct packed {
    logic tick;
    logic push;
    logic start;
  } tduart_cmd_t;

endpackage

>>> design/tick_driven_uart_8n1.sv
// A result appears on the master side in the cycle after its transaction is accepted.
// Throughput: one item per cycle while the result register is free or drains; each item is a
// single state update of the tx sequencer and rx sampler followed by the result register.
// The slave side keeps accepting while a finished result waits, as long as the result register
// is empty or being drained in the same cycle.
// Reset (rst_ni low, asynchronous): line high, not busy, buffer empty, receiver waits for high.
// ----------------------------------------------------------------------------
// tick_driven_uart_8n1
// Full-duplex 8n1 uart stepped by bit tick items, with push and start items for
// the transmit buffer. One result per item.
// ----------------------------------------------------------------------------
module tick_driven_uart_8n1 #(
  parameter int unsigned TX_DEPTH = tduart_pkg::TxDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] tx_byte, [8] rx_level, [15:9] zero
  input  logic [tduart_pkg::InDataW-1:0]    s_axis_tdata,
  // [1:0] opcode
  input  logic [tduart_pkg::OpW-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] tx_level, [1] tx_busy, [2] rx_valid, [10:3] rx_byte, [15:11] zero
  output logic [tduart_pkg::OutDataW-1:0]   m_axis_tdata
);
  import tduart_pkg::*;

  logic                s_fire;
  tduart_cmd_t         cmd;
  logic                tx_line;
  logic                tx_busy;
  logic                rx_valid;
  logic [ByteW-1:0]    rx_byte;
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  // accept whenever the result register is free or drains now
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // opcode decode for the accepted transaction
  always_comb begin
    cmd = '0;
    if (s_fire) begin
      case (s_axis_tuser)
        OP_TICK:  cmd.tick  = 1'b1;
        OP_PUSH:  cmd.push  = 1'b1;
        OP_START: cmd.start = 1'b1;
        default:  cmd       = '0;
      endcase
    end
  end

  tduart_tx #(
    .TX_DEPTH (TX_DEPTH)
  ) u_tx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .byte_i (s_axis_tdata[ByteW-1:0]),
    .line_o (tx_line),
    .busy_o (tx_busy)
  );

  tduart_rx u_rx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (cmd.tick),
    .level_i (s_axis_tdata[ByteW]),
    .valid_o (rx_valid),
    .byte_o  (rx_byte)
  );

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      out_data_q <= {(OutDataW - ByteW - 3)'(0), rx_byte, rx_valid, tx_busy, tx_line};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // every accepted transaction shows up as a result next cycle
  a_fire_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> m_axis_tvalid)
    else $error("accepted transaction produced no result");

  // rx valid only reported for tick transactions
  a_rx_valid_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_valid |-> (s_fire && s_axis_tuser == OP_TICK))
    else $error("rx valid on a non-tick transaction");

  // a waiting result is not overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !s_fire)
    else $error("result register overwritten while stalled");

endmodule

>>> design/tduart_tx.sv
// ----------------------------------------------------------------------------
// tduart_tx
// Transmit side: byte buffer, start control and the per-tick line sequencer.
// ----------------------------------------------------------------------------
module tduart_tx #(
  parameter int unsigned TX_DEPTH = tduart_pkg::TxDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tduart_pkg::tduart_cmd_t     cmd_i,
  input  logic [tduart_pkg::ByteW-1:0] byte_i,
  output logic                        line_o,
  output logic                        busy_o
);
  import tduart_pkg::*;

  localparam int unsigned CW = $clog2(TX_DEPTH + 1);
  localparam int unsigned AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

  // sequencer phase codes
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_CHECK = 3'd1;
  localparam logic [2:0] PH_LEAD  = 3'd2;
  localparam logic [2:0] PH_START = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_STOP  = 3'd5;

  logic [2:0]    phase_q, phase_d;
  logic          busy_q, busy_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [3:0]    bitn_q, bitn_d;
  logic          line_q, line_d;
  logic [CW-1:0] pos_inc;
  logic          wr_en;

  logic [ByteW-1:0] mem [TX_DEPTH];
  logic [ByteW-1:0] rd_data_q;

  assign wr_en   = cmd_i.push && !busy_q && (cnt_q < CW'(TX_DEPTH));
  assign pos_inc = pos_q + CW'(1);

  // buffer write on push while idle and not full, registered read of the byte in flight
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[AW-1:0]] <= byte_i;
    end
    rd_data_q <= mem[pos_q[AW-1:0]];
  end

  // next state for push, start and tick
  always_comb begin
    phase_d = phase_q;
    busy_d  = busy_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    bitn_d  = bitn_q;
    line_d  = line_q;
    if (wr_en) begin
      cnt_d = cnt_q + CW'(1);
    end
    if (cmd_i.start) begin
      busy_d = 1'b1;
    end
    if (cmd_i.tick) begin
      case (phase_q)
        PH_CHECK: begin
          if (cnt_q == '0) begin
            phase_d = PH_IDLE;
            busy_d  = 1'b0;
            cnt_d   = '0;
          end else begin
            phase_d = PH_LEAD;
          end
        end
        PH_LEAD: begin
          line_d  = 1'b1;
          phase_d = PH_START;
        end
        PH_START: begin
          line_d  = 1'b0;
          bitn_d  = '0;
          phase_d = PH_DATA;
        end
        PH_DATA: begin
          if (bitn_q < 4'd8) begin
            line_d = rd_data_q[bitn_q[2:0]];
            bitn_d = bitn_q + 4'd1;
          end else begin
            line_d  = 1'b1;
            phase_d = PH_STOP;
          end
        end
        PH_STOP: begin
          pos_d = pos_inc;
          if (pos_inc < cnt_q) begin
            phase_d = PH_LEAD;
          end else begin
            phase_d = PH_IDLE;
            busy_d  = 1'b0;
            cnt_d   = '0;
          end
        end
        default: begin
          phase_d = PH_IDLE;
          if (busy_q) begin
            pos_d   = '0;
            phase_d = PH_CHECK;
          end
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      busy_q  <= 1'b0;
      pos_q   <= '0;
      cnt_q   <= '0;
      bitn_q  <= '0;
      line_q  <= 1'b1;
    end else begin
      phase_q <= phase_d;
      busy_q  <= busy_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      bitn_q  <= bitn_d;
      line_q  <= line_d;
    end
  end

  // levels after this transaction
  assign line_o = line_d;
  assign busy_o = busy_d;

  // buffer fill never passes the depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TX_DEPTH))
    else $error("tx buffer count above depth");

  // a byte being sent lies inside the filled part of the buffer
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (pos_q < cnt_q))
    else $error("tx position outside buffered bytes");

  // the sequencer only runs while busy
  a_busy_when_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> busy_q)
    else $error("tx sequencer active while not busy");

endmodule

>>> design/tduart_rx.sv
// ----------------------------------------------------------------------------
// tduart_rx
// Receive side: start detection, eight data samples and stop check per tick.
// ----------------------------------------------------------------------------
module tduart_rx (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         tick_i,
  input  logic                         level_i,
  output logic                         valid_o,
  output logic [tduart_pkg::ByteW-1:0] byte_o
);
  import tduart_pkg::*;

  // receiver phase codes
  localparam logic [1:0] PH_WAIT_HIGH  = 2'd0;
  localparam logic [1:0] PH_WAIT_START = 2'd1;
  localparam logic [1:0] PH_DATA       = 2'd2;

  logic [1:0]       phase_q, phase_d;
  logic [3:0]       bitn_q, bitn_d;
  logic [ByteW-1:0] shift_q, shift_d;
  logic [ByteW-1:0] held_q, held_d;
  logic             valid;

  // next state on a tick
  always_comb begin
    phase_d = phase_q;
    bitn_d  = bitn_q;
    shift_d = shift_q;
    held_d  = held_q;
    valid   = 1'b0;
    if (tick_i) begin
      case (phase_q)
        PH_WAIT_START: begin
          if (!level_i) begin
            bitn_d  = '0;
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          if (bitn_q < 4'd8) begin
            shift_d[bitn_q[2:0]] = level_i;
            bitn_d = bitn_q + 4'd1;
          end else begin
            if (level_i) begin
              held_d = shift_q;
              valid  = 1'b1;
            end
            phase_d = PH_WAIT_START;
          end
        end
        default: begin
          phase_d = level_i ? PH_WAIT_START : PH_WAIT_HIGH;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT_HIGH;
      bitn_q  <= '0;
      held_q  <= '0;
    end else begin
      phase_q <= phase_d;
      bitn_q  <= bitn_d;
      held_q  <= held_d;
    end
  end

  // data shifter
  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

  assign valid_o = valid;
  assign byte_o  = held_d;

  // sample counter stays within one byte plus stop
  a_bitn_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bitn_q <= 4'd8)
    else $error("rx bit counter out of range");

  // a received byte is only reported on a tick
  a_valid_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid |-> (tick_i && phase_q == PH_DATA && bitn_q == 4'd8))
    else $error("rx valid outside stop sample");

  // held byte changes only with a good stop bit
  a_held_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid |=> $stable(held_q))
    else $error("rx held byte changed without a received byte");

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tick driven 8n1 uart. A short table of directed
// items runs first, then random message, receive-frame and noise traffic.
// Every result is compared with a local bit-accurate model of the block or with a
// fixed value from the table, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tduart_pkg::*;

  // unused opcode, must leave the state alone
  localparam logic [1:0] OpNone = 2'd3;
  localparam int unsigned TxDepth = TxDepthDef;
  localparam int unsigned ItemTarget = 1700;
  localparam int unsigned HoldCycles = 300;

  // result fields, first member in the top bits
  typedef struct packed {
    logic [4:0] pad;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       tx_busy;
    logic       tx_level;
  } uart_result_t;

  typedef enum logic [2:0] {
    TxIdle, TxCheck, TxLead, TxStart, TxData, TxStop
  } tx_phase_e;

  typedef enum logic [1:0] {
    RxWaitHigh, RxWaitStart, RxData
  } rx_phase_e;

  typedef struct {
    logic [1:0]   op;
    logic [7:0]   data;
    logic         level;
    bit           fixed;
    uart_result_t res;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [OpW-1:0]      s_axis_tuser = OP_TICK;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  tick_driven_uart_8n1 u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // model state, same reset values as the block
  tx_phase_e    exp_tx_phase = TxIdle;
  logic         exp_busy = 1'b0;
  logic [4:0]   exp_tx_pos = '0;
  logic [4:0]   exp_tx_count = '0;
  logic [3:0]   exp_tx_bit = '0;
  logic         exp_tx_line = 1'b1;
  logic [7:0]   exp_tx_buf [TxDepth];
  rx_phase_e    exp_rx_phase = RxWaitHigh;
  logic [3:0]   exp_rx_bit = '0;
  logic [7:0]   exp_rx_shift = '0;
  logic [7:0]   exp_rx_held = '0;

  uart_result_t outcome_q [$];
  logic         rx_wave_q [$];
  dir_row_t     dir_tab [19];
  int unsigned  errors = 0;
  int unsigned  items = 0;
  logic         in_fire = 1'b0;
  bit           fixed_valid = 1'b0;
  uart_result_t fixed_res = '0;
  bit           send_calm = 1'b0;
  bit           hold_req = 1'b0;

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic uart_result_t outcome(logic line, logic busy, logic valid,
                                           logic [7:0] rx_byte);
    uart_result_t r;
    r = '0;
    r.tx_level = line;
    r.tx_busy  = busy;
    r.rx_valid = valid;
    r.rx_byte  = rx_byte;
    return r;
  endfunction

  // one item through the uart model: transmitter first, then receiver
  function automatic uart_result_t uart_step(logic [1:0] op, logic [7:0] data,
                                             logic level);
    logic got;
    got = 1'b0;
    case (op)
      OP_TICK: begin
        case (exp_tx_phase)
          TxCheck: begin
            if (exp_tx_count == 0) begin
              exp_tx_phase = TxIdle;
              exp_busy     = 1'b0;
              exp_tx_count = '0;
            end else begin
              exp_tx_phase = TxLead;
            end
          end
          TxLead: begin
            exp_tx_line  = 1'b1;
            exp_tx_phase = TxStart;
          end
          TxStart: begin
            exp_tx_line  = 1'b0;
            exp_tx_bit   = '0;
            exp_tx_phase = TxData;
          end
          TxData: begin
            if (exp_tx_bit < 8) begin
              exp_tx_line = (exp_tx_pos < TxDepth) ?
                            exp_tx_buf[exp_tx_pos[3:0]][exp_tx_bit[2:0]] : 1'b0;
              exp_tx_bit++;
            end else begin
              exp_tx_line  = 1'b1;
              exp_tx_phase = TxStop;
            end
          end
          TxStop: begin
            exp_tx_pos++;
            if (exp_tx_pos < exp_tx_count) begin
              exp_tx_phase = TxLead;
            end else begin
              exp_tx_phase = TxIdle;
              exp_busy     = 1'b0;
              exp_tx_count = '0;
            end
          end
          default: begin
            exp_tx_phase = TxIdle;
            if (exp_busy) begin
              exp_tx_pos   = '0;
              exp_tx_phase = TxCheck;
            end
          end
        endcase
        // receiver samples after the transmitter moved
        case (exp_rx_phase)
          RxWaitStart: begin
            if (!level) begin
              exp_rx_bit   = '0;
              exp_rx_phase = RxData;
            end
          end
          RxData: begin
            if (exp_rx_bit < 8) begin
              exp_rx_shift[exp_rx_bit[2:0]] = level;
              exp_rx_bit++;
            end else begin
              if (level) begin
                exp_rx_held = exp_rx_shift;
                got = 1'b1;
              end
              exp_rx_phase = RxWaitStart;
            end
          end
          default: begin
            exp_rx_phase = level ? RxWaitStart : RxWaitHigh;
          end
        endcase
      end
      OP_PUSH: begin
        // ignored while busy or full
        if (!exp_busy && exp_tx_count < TxDepth) begin
          exp_tx_buf[exp_tx_count[3:0]] = data;
          exp_tx_count++;
        end
      end
      OP_START: begin
        exp_busy = 1'b1;
      end
      default: begin
      end
    endcase
    return outcome(exp_tx_line, exp_busy, got, exp_rx_held);
  endfunction

  // next receive line level: mostly whole frames, some noise
  function automatic logic next_rx_level();
    int unsigned n;
    if (rx_wave_q.size() == 0) begin
      if ($urandom_range(99) < 80) begin
        n = $urandom_range(3, 1);
        repeat (n) rx_wave_q.push_back(1'b1);
        rx_wave_q.push_back(1'b0);
        repeat (8) rx_wave_q.push_back(1'($urandom_range(1)));
        // a low stop bit now and then
        rx_wave_q.push_back($urandom_range(99) >= 10);
      end else begin
        n = $urandom_range(6, 1);
        repeat (n) rx_wave_q.push_back(1'($urandom_range(1)));
      end
    end
    return rx_wave_q.pop_front();
  endfunction

  function automatic void check_field(string name, int unsigned want,
                                      int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // offer one transaction and wait until it is taken
  task automatic send_item(input logic [1:0] op, input logic [7:0] data,
                           input logic level, input bit fixed = 1'b0,
                           input uart_result_t res = '0);
    while (!send_calm && $urandom_range(99) < 32) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    fixed_valid = fixed;
    fixed_res   = res;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, level, data};
    do begin
      @(posedge clk_i);
    end while (!in_fire);
    items++;
  endtask

  task automatic send_noise();
    logic [1:0] op;
    op = 2'($urandom_range(3));
    send_item(op, 8'($urandom_range(255)),
              (op == OP_TICK) ? next_rx_level() : logic'($urandom_range(1)));
  endtask

  // stop offering until every pending result has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (outcome_q.size() != 0);
  endtask

  // accept and compare, sampled away from the active edge
  always @(negedge clk_i) begin
    uart_result_t got;
    uart_result_t want;
    if (rst_ni) begin
      in_fire = s_axis_tvalid && s_axis_tready;
      if (in_fire) begin
        want = uart_step(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8]);
        if (fixed_valid) want = fixed_res;
        outcome_q.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (outcome_q.size() == 0) begin
          errors++;
          $display("%0t: result %h arrived with nothing expected", $time, got);
        end else begin
          want = outcome_q.pop_front();
          check_field("tx_level", 32'(want.tx_level), 32'(got.tx_level));
          check_field("tx_busy", 32'(want.tx_busy), 32'(got.tx_busy));
          check_field("rx_valid", 32'(want.rx_valid), 32'(got.rx_valid));
          check_field("rx_byte", 32'(want.rx_byte), 32'(got.rx_byte));
          check_field("pad", 32'(want.pad), 32'(got.pad));
        end
      end
    end
  end

  // result side: random stalls, one calm stretch, one long hold-off
  initial begin
    int unsigned sink_cycles;
    int unsigned held;
    bit hold_done;
    sink_cycles = 0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      sink_cycles++;
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        for (held = 0; held < HoldCycles; held++) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        m_axis_tready <= (sink_cycles >= 2500 && sink_cycles < 3500) ||
                         ($urandom_range(99) >= 32);
      end
    end
  end

  // stimulus
  initial begin
    int unsigned n;
    int unsigned pick;
    bit paused;
    paused = 1'b0;
    foreach (exp_tx_buf[i]) exp_tx_buf[i] = '0;
    dir_tab = '{
      '{OP_TICK,  8'h00, 1'b0, 1'b1, outcome(1'b1, 1'b0, 1'b0, 8'h00)},
      '{OpNone,   8'hFF, 1'b1, 1'b1, outcome(1'b1, 1'b0, 1'b0, 8'h00)},
      '{OP_PUSH,  8'h00, 1'b0, 1'b1, outcome(1'b1, 1'b0, 1'b0, 8'h00)},
      '{OP_PUSH,  8'hFF, 1'b1, 1'b1, outcome(1'b1, 1'b0, 1'b0, 8'h00)},
      '{OP_PUSH,  8'hA5, 1'b0, 1'b0, '0},
      '{OP_START, 8'h00, 1'b0, 1'b1, outcome(1'b1, 1'b1, 1'b0, 8'h00)},
      // start while busy
      '{OP_START, 8'hFF, 1'b1, 1'b1, outcome(1'b1, 1'b1, 1'b0, 8'h00)},
      // push while busy is dropped
      '{OP_PUSH,  8'h3C, 1'b0, 1'b0, '0},
      // receive 0x81 while the transmitter runs
      '{OP_TICK,  8'h00, 1'b1, 1'b0, '0},
      '{OP_TICK,  8'h00, 1'b0, 1'b0, '0},
      '{OP_TICK,  8'h00, 1'b1, 1'b0, '0},
      '{OP_TICK,  8'h00, 1'b0, 1'b0, '0},
      '{OP_TICK,  8'h00, 1'b0, 1'b0, '0},
      '{OP_TICK,  8'h00, 1'b0, 1'b0, '0},
      '{OP_TICK,  8'h00, 1'b0, 1'b0, '0},
      '{OP_TICK,  8'h00, 1'b0, 1'b0, '0},
      '{OP_TICK,  8'h00, 1'b0, 1'b0, '0},
      '{OP_TICK,  8'h00, 1'b1, 1'b0, '0},
      '{OP_TICK,  8'hFF, 1'b1, 1'b1, outcome(1'b0, 1'b1, 1'b1, 8'h81)}
    };
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].op, dir_tab[i].data, dir_tab[i].level,
                dir_tab[i].fixed, dir_tab[i].res);
    end
    wait_drained();

    // random traffic in episodes
    while (items < ItemTarget) begin
      send_calm = (items >= 700 && items < 1000);
      if (items >= 1300) hold_req = 1'b1;
      if (!paused && items >= 500) begin
        wait_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 75) begin
        // message: pushes, start, ticks until the transmitter is done
        pick = $urandom_range(99);
        n = (pick < 10) ? 0 : (pick < 85) ? $urandom_range(4, 1) : $urandom_range(18, 15);
        repeat (n) begin
          if ($urandom_range(99) < 5) send_noise();
          send_item(OP_PUSH, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        send_item(OP_START, 8'($urandom_range(255)), 1'($urandom_range(1)));
        while (exp_busy) begin
          if ($urandom_range(99) < 8) send_noise();
          else send_item(OP_TICK, 8'($urandom_range(255)), next_rx_level());
        end
        repeat ($urandom_range(5)) begin
          send_item(OP_TICK, 8'($urandom_range(255)), next_rx_level());
        end
      end else begin
        repeat ($urandom_range(20, 5)) send_noise();
      end
    end

    // drain and settle
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
design/tduart_pkg.sv
design/tduart_tx.sv
design/tduart_rx.sv
design/tick_driven_uart_8n1.sv
test/tb_top.sv
